@@ sv/pcda_pkg.sv @@
package pcda_pkg;

    // Field widths fixed by the interface
    localparam int PORT_W    = 6;
    localparam int BYTE_W    = 64;
    localparam int CNT_W     = 32;
    localparam int LIMIT_W   = 63;
    localparam int NUM_SMALL = 6;

    // Default table depth
    localparam int DEF_PORTS = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LIMIT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_NARROW     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_NARROW = 2'd2;

    localparam logic               RST_NARROW     = 1'b1;
    localparam logic [LIMIT_W-1:0] RST_MAX_WIDE   = 63'd10000000000000;
    localparam logic [CNT_W-1:0]   RST_MAX_NARROW = 32'h7FFF_FFFF;

    // Slots of the small counters: packets, errors, drops, rx then tx
    localparam int SM_PKT_RX = 0;
    localparam int SM_ERR_RX = 1;
    localparam int SM_DRP_RX = 2;
    localparam int SM_PKT_TX = 3;
    localparam int SM_ERR_TX = 4;
    localparam int SM_DRP_TX = 5;

    typedef logic [NUM_SMALL-1:0][CNT_W-1:0] t_small;

    typedef struct packed {
        logic [BYTE_W-1:0] sum_brx;
        logic [BYTE_W-1:0] sum_btx;
        t_small            sum_small;
    } t_sums;

    // One table row per port
    typedef struct packed {
        logic              seen;
        logic [BYTE_W-1:0] last_brx;
        logic [BYTE_W-1:0] last_btx;
        logic [CNT_W-1:0]  last_nrx;
        logic [CNT_W-1:0]  last_ntx;
        t_small            last_small;
        t_sums             sums;
    } t_row;

    typedef struct packed {
        logic [BYTE_W-1:0] brx;
        logic [BYTE_W-1:0] btx;
        t_small            small_cnt;
    } t_sample;

    typedef struct packed {
        logic [BYTE_W-1:0] drx;
        logic [BYTE_W-1:0] dtx;
        t_small            dsmall;
    } t_delta;

    typedef struct packed {
        logic disc;
        logic first;
        logic wide_hit;
    } t_flags;

endpackage

@@ sv/port_counter_delta_accumulator_core.sv @@
// Channel  Handshake                  Payload
// in       i_in_valid / o_in_ready    i_port_index, i_raw_* counter readings
// out      o_out_valid / i_out_ready  o_total_*, o_discontinuity, o_first_sample,
//                                     o_wide_mode_active
// cfg      i_cfg_we                   i_cfg_index, i_cfg_data
//
// Each beat passes through accept and table read, delta step, then limit
// check, sums and write back of the port's row. The table read is
// registered, and a single row is read, modified and written back serially.
// After reset a clearing pass zeroes the table; no input is taken meanwhile.
// A finished result waits in the output register while the next beat is
// accepted; write back holds until the output register is free.
module port_counter_delta_accumulator_core
    import pcda_pkg::*;
#(
    parameter int PORTS = DEF_PORTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PORT_W-1:0]     i_port_index,
    input  logic [BYTE_W-1:0]     i_raw_bytes_rx,
    input  logic [CNT_W-1:0]      i_raw_packets_rx,
    input  logic [CNT_W-1:0]      i_raw_errors_rx,
    input  logic [CNT_W-1:0]      i_raw_drops_rx,
    input  logic [BYTE_W-1:0]     i_raw_bytes_tx,
    input  logic [CNT_W-1:0]      i_raw_packets_tx,
    input  logic [CNT_W-1:0]      i_raw_errors_tx,
    input  logic [CNT_W-1:0]      i_raw_drops_tx,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [BYTE_W-1:0]     o_total_bytes_rx,
    output logic [CNT_W-1:0]      o_total_packets_rx,
    output logic [CNT_W-1:0]      o_total_errors_rx,
    output logic [CNT_W-1:0]      o_total_drops_rx,
    output logic [BYTE_W-1:0]     o_total_bytes_tx,
    output logic [CNT_W-1:0]      o_total_packets_tx,
    output logic [CNT_W-1:0]      o_total_errors_tx,
    output logic [CNT_W-1:0]      o_total_drops_tx,
    output logic                  o_discontinuity,
    output logic                  o_first_sample,
    output logic                  o_wide_mode_active
);

    localparam int AW = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(PORTS - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DELTA,
        S_WRITE
    } t_state;

    t_state               r_state, n_state;
    logic [AW-1:0]        r_clr_addr;
    logic [AW-1:0]        r_addr;
    logic                 r_in_range;
    logic                 r_narrow;
    logic                 r_wide_seen, n_wide_seen;
    t_sample              r_sample;
    t_row                 r_row;
    t_delta               r_delta;

    logic                 r_cfg_narrow;
    logic [LIMIT_W-1:0]   r_max_wide;
    logic [CNT_W-1:0]     r_max_narrow;

    logic                 r_out_valid;
    t_sums                r_out_sums;
    logic                 r_out_disc;
    logic                 r_out_first;
    logic                 r_out_wide;

    logic                 in_fire;
    logic                 wb_go;
    logic                 narrow_now;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    t_row                 mem_wdata;
    t_row                 mem_rdata;
    t_delta               delta;
    t_row                 new_row;
    t_flags               flags;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid & o_in_ready;
    assign wb_go      = (r_state == S_WRITE) & (~r_out_valid | i_out_ready);
    assign narrow_now = r_cfg_narrow & ~r_wide_seen;

    // Row table: clearing pass after reset, else write back of one port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = new_row;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (wb_go && r_in_range) begin
            mem_we = 1'b1;
        end
    end

    pcda_mem #(
        .DEPTH (PORTS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (AW'(i_port_index)),
        .o_rdata (mem_rdata)
    );

    pcda_delta u_delta (
        .i_row    (mem_rdata),
        .i_sample (r_sample),
        .i_narrow (narrow_now),
        .o_delta  (delta)
    );

    pcda_merge u_merge (
        .i_row        (r_row),
        .i_sample     (r_sample),
        .i_delta      (r_delta),
        .i_narrow     (r_narrow),
        .i_max_wide   (r_max_wide),
        .i_max_narrow (r_max_narrow),
        .o_row        (new_row),
        .o_flags      (flags)
    );

    // Next state and mode
    always_comb begin
        n_state     = r_state;
        n_wide_seen = r_wide_seen;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_DELTA;
                end
            end
            S_DELTA: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (wb_go) begin
                    n_state = S_IDLE;
                    if (r_in_range && flags.wide_hit) begin
                        n_wide_seen = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, configuration, pipeline and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_wide_seen  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cfg_narrow <= RST_NARROW;
            r_max_wide   <= RST_MAX_WIDE;
            r_max_narrow <= RST_MAX_NARROW;
        end else begin
            r_state     <= n_state;
            r_wide_seen <= n_wide_seen;

            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end

            // Take configuration writes; drop unknown indexes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NARROW:     r_cfg_narrow <= i_cfg_data[0];
                    CFG_MAX_WIDE:   r_max_wide   <= i_cfg_data;
                    CFG_MAX_NARROW: r_max_narrow <= i_cfg_data[CNT_W-1:0];
                    default:        ;
                endcase
            end

            // Latch the incoming beat
            if (in_fire) begin
                r_addr     <= AW'(i_port_index);
                r_in_range <= (32'(i_port_index) < PORTS);
                r_sample.brx <= i_raw_bytes_rx;
                r_sample.btx <= i_raw_bytes_tx;
                r_sample.small_cnt[SM_PKT_RX] <= i_raw_packets_rx;
                r_sample.small_cnt[SM_ERR_RX] <= i_raw_errors_rx;
                r_sample.small_cnt[SM_DRP_RX] <= i_raw_drops_rx;
                r_sample.small_cnt[SM_PKT_TX] <= i_raw_packets_tx;
                r_sample.small_cnt[SM_ERR_TX] <= i_raw_errors_tx;
                r_sample.small_cnt[SM_DRP_TX] <= i_raw_drops_tx;
            end

            // Hold the row and its deltas for the write-back step
            if (r_state == S_DELTA) begin
                r_row    <= mem_rdata;
                r_delta  <= delta;
                r_narrow <= narrow_now;
            end

            // Release the result beat, load the next one
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (wb_go) begin
                r_out_valid <= 1'b1;
                r_out_wide  <= ~(r_cfg_narrow & ~n_wide_seen);
                if (r_in_range) begin
                    r_out_sums  <= new_row.sums;
                    r_out_disc  <= flags.disc;
                    r_out_first <= flags.first;
                end else begin
                    r_out_sums  <= '0;
                    r_out_disc  <= 1'b0;
                    r_out_first <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_total_bytes_rx   = r_out_sums.sum_brx;
    assign o_total_bytes_tx   = r_out_sums.sum_btx;
    assign o_total_packets_rx = r_out_sums.sum_small[SM_PKT_RX];
    assign o_total_errors_rx  = r_out_sums.sum_small[SM_ERR_RX];
    assign o_total_drops_rx   = r_out_sums.sum_small[SM_DRP_RX];
    assign o_total_packets_tx = r_out_sums.sum_small[SM_PKT_TX];
    assign o_total_errors_tx  = r_out_sums.sum_small[SM_ERR_TX];
    assign o_total_drops_tx   = r_out_sums.sum_small[SM_DRP_TX];
    assign o_discontinuity    = r_out_disc;
    assign o_first_sample     = r_out_first;
    assign o_wide_mode_active = r_out_wide;

    // Wide mode, once entered, stays until reset
    a_wide_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wide_seen |=> r_wide_seen)
        else $error("wide mode left without reset");

    // A port is never both new and discontinuous
    a_first_no_disc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_first_sample && o_discontinuity))
        else $error("first sample flagged as discontinuity");

    // An accepted beat passes through the delta step and then reaches write back
    a_beat_to_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> ##2 (r_state == S_WRITE))
        else $error("accepted beat did not reach write back");

    // The table is written only while clearing or on write back
    a_write_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLEAR || (wb_go && r_in_range)))
        else $error("unexpected table write");

endmodule

@@ sv/pcda_mem.sv @@
module pcda_mem
    import pcda_pkg::*;
#(
    parameter int DEPTH = DEF_PORTS,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_row          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_row          o_rdata
);

    t_row r_mem [DEPTH];
    t_row r_rdata;

    // Write one row, read one row with a registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/pcda_delta.sv @@
module pcda_delta
    import pcda_pkg::*;
(
    input  t_row    i_row,
    input  t_sample i_sample,
    input  logic    i_narrow,
    output t_delta  o_delta
);

    logic [CNT_W-1:0] nrx;
    logic [CNT_W-1:0] ntx;

    // Byte deltas: 32-bit wrap in narrow mode, full width otherwise.
    // Small counter deltas wrap at 32 bits.
    always_comb begin
        nrx = i_sample.brx[CNT_W-1:0] - i_row.last_nrx;
        ntx = i_sample.btx[CNT_W-1:0] - i_row.last_ntx;
        if (i_narrow) begin
            o_delta.drx = {{(BYTE_W-CNT_W){1'b0}}, nrx};
            o_delta.dtx = {{(BYTE_W-CNT_W){1'b0}}, ntx};
        end else begin
            o_delta.drx = i_sample.brx - i_row.last_brx;
            o_delta.dtx = i_sample.btx - i_row.last_btx;
        end
        for (int k = 0; k < NUM_SMALL; k++) begin
            o_delta.dsmall[k] = i_sample.small_cnt[k] - i_row.last_small[k];
        end
    end

endmodule

@@ sv/pcda_merge.sv @@
module pcda_merge
    import pcda_pkg::*;
(
    input  t_row               i_row,
    input  t_sample            i_sample,
    input  t_delta             i_delta,
    input  logic               i_narrow,
    input  logic [LIMIT_W-1:0] i_max_wide,
    input  logic [CNT_W-1:0]   i_max_narrow,
    output t_row               o_row,
    output t_flags             o_flags
);

    logic [BYTE_W-1:0] limit;
    logic              over;
    logic              acc;

    // Check the deltas against their limits
    always_comb begin
        limit = i_narrow ? {{(BYTE_W-CNT_W){1'b0}}, i_max_narrow}
                         : {{(BYTE_W-LIMIT_W){1'b0}}, i_max_wide};
        over  = (i_delta.drx > limit) || (i_delta.dtx > limit) ||
                (i_delta.dsmall[SM_PKT_RX] > i_max_narrow) ||
                (i_delta.dsmall[SM_PKT_TX] > i_max_narrow);
        o_flags.first    = ~i_row.seen;
        o_flags.disc     = i_row.seen & over;
        o_flags.wide_hit = i_narrow & ((|i_sample.brx[BYTE_W-1:CNT_W]) |
                                       (|i_sample.btx[BYTE_W-1:CNT_W]));
        acc = i_row.seen & ~over;
    end

    // Build the row to write back
    always_comb begin
        o_row.seen       = 1'b1;
        o_row.last_brx   = i_sample.brx;
        o_row.last_btx   = i_sample.btx;
        o_row.last_nrx   = i_narrow ? i_sample.brx[CNT_W-1:0] : i_row.last_nrx;
        o_row.last_ntx   = i_narrow ? i_sample.btx[CNT_W-1:0] : i_row.last_ntx;
        o_row.last_small = i_sample.small_cnt;
        o_row.sums       = i_row.sums;
        if (acc) begin
            o_row.sums.sum_brx = i_row.sums.sum_brx + i_delta.drx;
            o_row.sums.sum_btx = i_row.sums.sum_btx + i_delta.dtx;
            for (int k = 0; k < NUM_SMALL; k++) begin
                o_row.sums.sum_small[k] = i_row.sums.sum_small[k] + i_delta.dsmall[k];
            end
        end
    end

endmodule
